// ===== rtl/shash_pkg.sv =====
// Shared types and constants of the SHA-256 stream hasher.
package shash_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned BLOCK_W = 512;
    localparam int unsigned ROUNDS  = 64;

    localparam logic [7:0] PAD_BYTE     = 8'h80;
    localparam logic [5:0] LEN_POS      = 6'd56;
    localparam logic [2:0] MAX_BYTES    = 3'd4;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] HASH_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef enum logic [1:0] {
        SEL_DATA,
        SEL_PAD,
        SEL_ZERO,
        SEL_LEN
    } byte_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DATA,
        ST_PAD,
        ST_ZERO,
        ST_LEN,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic      accept;
        logic      push;
        byte_sel_t byte_sel;
        logic      load;
        logic      round;
        logic      add;
        logic      finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic cnt_zero;
        logic eom;
        logic block_full;
        logic at_len_pos;
        logic round_last;
        logic out_busy;
    } dp_status_t;

endpackage

// ===== rtl/shash_ctrl.sv =====
// Sequencer for byte absorption, padding, compression and digest hand-off.
module shash_ctrl
    import shash_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    ctrl_state_t state_reg, state_next;
    ctrl_state_t ret_reg, ret_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        ret_next     = ret_reg;
        cmd          = '0;
        cmd.byte_sel = SEL_DATA;
        in_ready     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_DATA;
                end
            end
            ST_DATA:
            begin
                if (status.cnt_zero)
                begin
                    state_next = status.eom ? ST_PAD : ST_IDLE;
                end
                else
                begin
                    cmd.push     = 1'b1;
                    cmd.byte_sel = SEL_DATA;
                    if (status.block_full)
                    begin
                        state_next = ST_LOAD;
                        ret_next   = ST_DATA;
                    end
                end
            end
            ST_PAD:
            begin
                cmd.push     = 1'b1;
                cmd.byte_sel = SEL_PAD;
                state_next   = status.block_full ? ST_LOAD : ST_ZERO;
                ret_next     = ST_ZERO;
            end
            ST_ZERO:
            begin
                // stop at the length field; a block that fills on zeros compresses first
                if (status.at_len_pos)
                begin
                    state_next = ST_LEN;
                end
                else
                begin
                    cmd.push     = 1'b1;
                    cmd.byte_sel = SEL_ZERO;
                    if (status.block_full)
                    begin
                        state_next = ST_LOAD;
                        ret_next   = ST_ZERO;
                    end
                end
            end
            ST_LEN:
            begin
                cmd.push     = 1'b1;
                cmd.byte_sel = SEL_LEN;
                if (status.block_full)
                begin
                    state_next = ST_LOAD;
                    ret_next   = ST_DONE;
                end
            end
            ST_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                cmd.round = 1'b1;
                if (status.round_last)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                cmd.add    = 1'b1;
                state_next = ret_reg;
            end
            ST_DONE:
            begin
                // hold the digest until the output register drains
                if (!status.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (state_reg == ST_IDLE))
        else $error("in_ready outside idle");

    a_round_to_add: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ADD) |-> ($past(state_reg) == ST_ROUND))
        else $error("add without preceding round");

    a_len_returns_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LEN && status.block_full) |=> (ret_reg == ST_DONE))
        else $error("final block not marked");

endmodule

// ===== rtl/shash_datapath.sv =====
// Block buffer, message schedule, round logic, hash state and digest output register.
module shash_datapath
    import shash_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  ctrl_cmd_t   cmd,
    output dp_status_t  status,
    input  logic [31:0] data_word,
    input  logic [2:0]  byte_count,
    input  logic        end_of_message,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] digest_part,
    output logic [1:0]  part_index,
    output logic        last_part
);

    function automatic logic [31:0] big_sig0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sig1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sig0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sig1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
    endfunction

    logic [31:0]        word_reg, word_next;
    logic [2:0]         cnt_reg, cnt_next;
    logic               eom_reg, eom_next;
    logic [63:0]        bits_reg, bits_next;
    logic [5:0]         fill_reg, fill_next;
    logic [BLOCK_W-1:0] buf_reg, buf_next;
    logic [5:0]         rcnt_reg, rcnt_next;
    logic [31:0]        hash_reg [8];
    logic [31:0]        hash_next [8];
    logic [31:0]        var_reg [8];
    logic [31:0]        var_next [8];
    logic [255:0]       dig_reg, dig_next;
    logic [1:0]         part_reg, part_next;
    logic               busy_reg, busy_next;

    logic [2:0]  sat_cnt;
    logic [7:0]  len_byte;
    logic [7:0]  push_byte;
    logic [31:0] w0, w1, w9, w14, w_new;
    logic [31:0] t1, t2;
    logic        out_fire;

    assign sat_cnt  = (byte_count > MAX_BYTES) ? MAX_BYTES : byte_count;
    assign len_byte = 8'(bits_reg >> {~fill_reg[2:0], 3'b000});

    // schedule window: w0 is the word for this round, the rest are fixed taps
    assign w0    = buf_reg[511:480];
    assign w1    = buf_reg[479:448];
    assign w9    = buf_reg[223:192];
    assign w14   = buf_reg[63:32];
    assign w_new = small_sig1(w14) + w9 + small_sig0(w1) + w0;

    assign t1 = var_reg[7] + big_sig1(var_reg[4])
              + ((var_reg[4] & var_reg[5]) ^ (~var_reg[4] & var_reg[6]))
              + ROUND_K[rcnt_reg] + w0;
    assign t2 = big_sig0(var_reg[0])
              + ((var_reg[0] & var_reg[1]) ^ (var_reg[0] & var_reg[2])
                 ^ (var_reg[1] & var_reg[2]));

    assign out_fire = busy_reg && out_ready;

    always_comb
    begin
        case (cmd.byte_sel)
            SEL_DATA: push_byte = word_reg[31:24];
            SEL_PAD:  push_byte = PAD_BYTE;
            SEL_ZERO: push_byte = 8'h00;
            SEL_LEN:  push_byte = len_byte;
            default:  push_byte = 8'h00;
        endcase
    end

    always_comb
    begin
        word_next = word_reg;
        cnt_next  = cnt_reg;
        eom_next  = eom_reg;
        bits_next = bits_reg;
        fill_next = fill_reg;
        buf_next  = buf_reg;
        rcnt_next = rcnt_reg;
        hash_next = hash_reg;
        var_next  = var_reg;
        dig_next  = dig_reg;
        part_next = part_reg;
        busy_next = busy_reg;

        if (cmd.accept)
        begin
            word_next = data_word;
            cnt_next  = sat_cnt;
            eom_next  = end_of_message;
            bits_next = bits_reg + 64'({sat_cnt, 3'b000});
        end

        if (cmd.push)
        begin
            buf_next  = {buf_reg[BLOCK_W-9:0], push_byte};
            fill_next = fill_reg + 6'd1;
            if (cmd.byte_sel == SEL_DATA)
            begin
                word_next = {word_reg[23:0], 8'h00};
                cnt_next  = cnt_reg - 3'd1;
            end
        end

        if (cmd.load)
        begin
            var_next  = hash_reg;
            rcnt_next = '0;
        end

        if (cmd.round)
        begin
            buf_next    = {buf_reg[BLOCK_W-WORD_W-1:0], w_new};
            rcnt_next   = rcnt_reg + 6'd1;
            var_next[7] = var_reg[6];
            var_next[6] = var_reg[5];
            var_next[5] = var_reg[4];
            var_next[4] = var_reg[3] + t1;
            var_next[3] = var_reg[2];
            var_next[2] = var_reg[1];
            var_next[1] = var_reg[0];
            var_next[0] = t1 + t2;
        end

        if (cmd.add)
        begin
            for (int i = 0; i < 8; i++)
            begin
                hash_next[i] = hash_reg[i] + var_reg[i];
            end
        end

        if (out_fire)
        begin
            dig_next  = {dig_reg[191:0], 64'h0};
            part_next = part_reg + 2'd1;
            if (part_reg == 2'd3)
            begin
                busy_next = 1'b0;
            end
        end

        // hand the digest to the output register and start a fresh message
        if (cmd.finish)
        begin
            dig_next  = {hash_reg[0], hash_reg[1], hash_reg[2], hash_reg[3],
                         hash_reg[4], hash_reg[5], hash_reg[6], hash_reg[7]};
            part_next = '0;
            busy_next = 1'b1;
            hash_next = HASH_IV;
            bits_next = '0;
            fill_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            eom_reg  <= 1'b0;
            bits_reg <= '0;
            fill_reg <= '0;
            rcnt_reg <= '0;
            hash_reg <= HASH_IV;
            part_reg <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            eom_reg  <= eom_next;
            bits_reg <= bits_next;
            fill_reg <= fill_next;
            rcnt_reg <= rcnt_next;
            hash_reg <= hash_next;
            part_reg <= part_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        buf_reg  <= buf_next;
        var_reg  <= var_next;
        dig_reg  <= dig_next;
    end

    assign status.cnt_zero   = (cnt_reg == 3'd0);
    assign status.eom        = eom_reg;
    assign status.block_full = (fill_reg == 6'd63);
    assign status.at_len_pos = (fill_reg == LEN_POS);
    assign status.round_last = (rcnt_reg == 6'(ROUNDS - 1));
    assign status.out_busy   = busy_reg;

    assign out_valid   = busy_reg;
    assign digest_part = dig_reg[255:192];
    assign part_index  = part_reg;
    assign last_part   = (part_reg == 2'd3);

    a_finish_block_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (fill_reg == 6'd0))
        else $error("finish with a partial block");

    a_finish_output_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !busy_reg)
        else $error("digest overwritten before drained");

    a_add_after_all_rounds: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.add |-> (rcnt_reg == 6'd0 && $past(cmd.round)))
        else $error("hash update before round 63 completed");

    a_data_push_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.push && cmd.byte_sel == SEL_DATA) |-> (cnt_reg != 3'd0))
        else $error("data byte pushed with none left");

endmodule

// ===== rtl/sha256_stream_hasher.sv =====
// SHA-256 stream hasher top level: sequencer plus datapath.
// Input channel (in_valid/in_ready): each transaction carries data_word with
// byte_count leading bytes (first byte in bits 31..24; counts 5..7 act as 4)
// and end_of_message. Output channel (out_valid/out_ready): after a message
// ends, four transactions carry the digest, part_index 0..3, last_part on 3.
// Throughput: bytes are absorbed one per cycle while no block compresses;
// a new item is accepted only once all bytes of the previous one are in.
// Each completed 64-byte block is compressed by a load, 64 rounds at one
// round per cycle and a hash update; the round adder chain sets the clock.
// Padding pushes 0x80, zero fill and the 8 length bytes one per cycle as
// well (same pause); the last block compresses before part 0 is presented.
// The digest moves into its own output register, so the next message is
// accepted while the receiver still stalls; a later digest waits in the
// sequencer until the previous four parts are taken.
// Reset puts the hash words at the standard initial values, clears the
// length and fill counts and drops any pending output.
module sha256_stream_hasher
    import shash_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] data_word,
    input  logic [2:0]  byte_count,
    input  logic        end_of_message,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] digest_part,
    output logic [1:0]  part_index,
    output logic        last_part
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    shash_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    shash_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .data_word      (data_word),
        .byte_count     (byte_count),
        .end_of_message (end_of_message),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .digest_part    (digest_part),
        .part_index     (part_index),
        .last_part      (last_part)
    );

endmodule
